// ===== src/soh_stx_etx_frame_parser_crc16_defines.svh =====
// Assertion macros shared by the frame parser RTL.
`ifndef SOH_STX_ETX_FRAME_PARSER_CRC16_DEFINES_SVH
`define SOH_STX_ETX_FRAME_PARSER_CRC16_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/sfp_pkg.sv =====
package sfp_pkg;

    localparam int MAX_FRAME = 1024;
    localparam int POS_W     = $clog2(MAX_FRAME);
    localparam int CMP_W     = (POS_W >= 8) ? POS_W + 1 : 9;

    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_ETX = 8'h03;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_SHORT       = 4'd1;
    localparam logic [3:0] ST_HEADER      = 4'd2;
    localparam logic [3:0] ST_PROTOCOL    = 4'd3;
    localparam logic [3:0] ST_INPORT      = 4'd4;
    localparam logic [3:0] ST_OUTPORT     = 4'd5;
    localparam logic [3:0] ST_LEN_HEX     = 4'd6;
    localparam logic [3:0] ST_LEN_MISMATCH = 4'd7;
    localparam logic [3:0] ST_CRC_HEX     = 4'd8;
    localparam logic [3:0] ST_CRC_MISMATCH = 4'd9;
    localparam logic [3:0] ST_TOO_LONG    = 4'd10;

    localparam logic [1:0] REG_UDP_CODE = 2'd0;
    localparam logic [1:0] REG_TCP_CODE = 2'd1;
    localparam logic [1:0] REG_MIN_LEN  = 2'd2;

    localparam logic [7:0] RST_UDP_CODE = 8'd85;
    localparam logic [7:0] RST_TCP_CODE = 8'd84;
    localparam logic [7:0] RST_MIN_LEN  = 8'd20;

    typedef enum logic {
        PH_HUNT,
        PH_FRAME
    } phase_t;

    typedef struct packed {
        logic [7:0] udp_code;
        logic [7:0] tcp_code;
        logic [7:0] min_frame_len;
    } cfg_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } byte_item_t;

    typedef struct packed {
        logic        item_kind;
        logic [7:0]  payload_char;
        logic [3:0]  status;
        logic [7:0]  protocol;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [15:0] text_length;
        logic [15:0] frame_check;
    } result_t;

    // {bad, value}: bad is set for anything but 0-9, a-f, A-F
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'b1_0000;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b0, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66)
            r = {1'b0, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46)
            r = {1'b0, 4'(c - 8'h37)};
        return r;
    endfunction

    // CRC-16/CCITT-FALSE, one byte, table-free form
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] x;
        x = crc[15:8] ^ b;
        x = x ^ {4'b0, x[7:4]};
        return {crc[7:0], 8'h00} ^ {x[3:0], 12'h000} ^ {3'b000, x, 5'b00000}
               ^ {8'h00, x};
    endfunction

    // keep the lowest code seen so far
    function automatic logic [3:0] note_error(input logic [3:0] e, input logic [3:0] code);
        return (e == ST_OK || code < e) ? code : e;
    endfunction

endpackage

// ===== src/sfp_cfg_regs.sv =====
module sfp_cfg_regs
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [3:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output sfp_pkg::cfg_t    cfg
);

    sfp_pkg::cfg_t cfg_reg;
    sfp_pkg::cfg_t cfg_next;
    logic          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (paddr[3:2])
                sfp_pkg::REG_UDP_CODE: cfg_next.udp_code      = pwdata[7:0];
                sfp_pkg::REG_TCP_CODE: cfg_next.tcp_code      = pwdata[7:0];
                sfp_pkg::REG_MIN_LEN:  cfg_next.min_frame_len = pwdata[7:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            sfp_pkg::REG_UDP_CODE: prdata = {24'h0, cfg_reg.udp_code};
            sfp_pkg::REG_TCP_CODE: prdata = {24'h0, cfg_reg.tcp_code};
            sfp_pkg::REG_MIN_LEN:  prdata = {24'h0, cfg_reg.min_frame_len};
            default:               prdata = 32'h0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.udp_code      <= sfp_pkg::RST_UDP_CODE;
            cfg_reg.tcp_code      <= sfp_pkg::RST_TCP_CODE;
            cfg_reg.min_frame_len <= sfp_pkg::RST_MIN_LEN;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== src/sfp_in_stage.sv =====
module sfp_in_stage
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,
    input  logic                 take,
    output sfp_pkg::byte_item_t  item
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       load;

    // free slot, or the held byte leaves this cycle
    assign s_tready = !valid_reg || take;
    assign load     = s_tvalid && s_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= s_tdata;
    end

    assign item.valid = valid_reg;
    assign item.data  = data_reg;

endmodule

// ===== src/sfp_frame_core.sv =====
`include "soh_stx_etx_frame_parser_crc16_defines.svh"

module sfp_frame_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  sfp_pkg::cfg_t        cfg,
    input  logic                 advance,
    input  logic [7:0]           data_byte,
    output logic                 res_valid,
    output sfp_pkg::result_t     res
);

    localparam int PW = sfp_pkg::POS_W;
    localparam int CW = sfp_pkg::CMP_W;

    sfp_pkg::phase_t       phase_reg, phase_next;
    logic [PW-1:0]         pos_reg, pos_next;
    logic [PW-1:0]         count_reg, count_next;
    logic [3:0]            err_reg, err_next;
    logic [15:0]           crc_reg, crc_next;
    logic [7:0]            proto_reg, proto_next;
    logic [15:0]           in_port_reg, in_port_next;
    logic [15:0]           out_port_reg, out_port_next;
    logic [15:0]           len_reg, len_next;
    logic [7:0]            tail_reg [4];
    logic [7:0]            tail_next [4];

    logic [4:0]            hex_in;
    logic [4:0]            hex_tail [4];
    logic                  tail_bad;
    logic [15:0]           tail_fc;
    logic [3:0]            etx_err;
    logic [CW-1:0]         frame_len;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
            hex_tail[k] = sfp_pkg::hex_decode(tail_reg[k]);
        tail_bad = hex_tail[0][4] | hex_tail[1][4] | hex_tail[2][4] | hex_tail[3][4];
        tail_fc  = {hex_tail[0][3:0], hex_tail[1][3:0], hex_tail[2][3:0], hex_tail[3][3:0]};
    end

    assign hex_in    = sfp_pkg::hex_decode(data_byte);
    assign frame_len = CW'(pos_reg) + CW'(1);

    always_comb
    begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        count_next    = count_reg;
        err_next      = err_reg;
        crc_next      = crc_reg;
        proto_next    = proto_reg;
        in_port_next  = in_port_reg;
        out_port_next = out_port_reg;
        len_next      = len_reg;
        for (int k = 0; k < 4; k++)
            tail_next[k] = tail_reg[k];
        etx_err   = err_reg;
        res_valid = 1'b0;
        res       = '0;

        if (advance)
        begin
            case (phase_reg)
                sfp_pkg::PH_HUNT:
                begin
                    if (data_byte == sfp_pkg::CH_SOH)
                    begin
                        phase_next    = sfp_pkg::PH_FRAME;
                        pos_next      = PW'(1);
                        crc_next      = sfp_pkg::CRC_INIT;
                        tail_next[0]  = 8'h00;
                        tail_next[1]  = 8'h00;
                        tail_next[2]  = 8'h00;
                        tail_next[3]  = sfp_pkg::CH_SOH;
                        err_next      = sfp_pkg::ST_OK;
                        proto_next    = 8'h00;
                        in_port_next  = 16'h0;
                        out_port_next = 16'h0;
                        len_next      = 16'h0;
                        count_next    = '0;
                    end
                end

                sfp_pkg::PH_FRAME:
                begin
                    if (data_byte == sfp_pkg::CH_ETX)
                    begin
                        if (pos_reg <= PW'(10))
                            etx_err = sfp_pkg::note_error(etx_err, sfp_pkg::ST_HEADER);
                        if (pos_reg > PW'(10) && pos_reg <= PW'(14))
                            etx_err = sfp_pkg::note_error(etx_err, sfp_pkg::ST_LEN_HEX);
                        if (pos_reg < PW'(19) || 16'(count_reg) != len_reg)
                            etx_err = sfp_pkg::note_error(etx_err, sfp_pkg::ST_LEN_MISMATCH);
                        if (tail_bad)
                            etx_err = sfp_pkg::note_error(etx_err, sfp_pkg::ST_CRC_HEX);
                        else if (tail_fc != crc_reg)
                            etx_err = sfp_pkg::note_error(etx_err, sfp_pkg::ST_CRC_MISMATCH);
                        if (frame_len < CW'(cfg.min_frame_len))
                            etx_err = sfp_pkg::ST_SHORT;

                        res_valid     = 1'b1;
                        res.item_kind = sfp_pkg::KIND_STATUS;
                        res.status    = etx_err;
                        if (etx_err == sfp_pkg::ST_OK)
                        begin
                            res.protocol    = proto_reg;
                            res.source_port = in_port_reg;
                            res.dest_port   = out_port_reg;
                            res.text_length = len_reg;
                            res.frame_check = tail_fc;
                        end
                        phase_next = sfp_pkg::PH_HUNT;
                    end
                    else if (pos_reg == PW'(sfp_pkg::MAX_FRAME - 1))
                    begin
                        res_valid     = 1'b1;
                        res.item_kind = sfp_pkg::KIND_STATUS;
                        res.status    = sfp_pkg::ST_TOO_LONG;
                        phase_next    = sfp_pkg::PH_HUNT;
                    end
                    else
                    begin
                        if (pos_reg < PW'(10) && data_byte == sfp_pkg::CH_STX)
                            err_next = sfp_pkg::note_error(err_next, sfp_pkg::ST_HEADER);

                        case (pos_reg) inside
                            PW'(1):
                            begin
                                proto_next = data_byte;
                                if (data_byte != cfg.udp_code && data_byte != cfg.tcp_code)
                                    err_next = sfp_pkg::note_error(err_next,
                                                                   sfp_pkg::ST_PROTOCOL);
                            end
                            [PW'(2):PW'(5)]:
                            begin
                                in_port_next = {in_port_reg[11:0],
                                                hex_in[4] ? 4'h0 : hex_in[3:0]};
                                if (hex_in[4])
                                    err_next = sfp_pkg::note_error(err_next, sfp_pkg::ST_INPORT);
                            end
                            [PW'(6):PW'(9)]:
                            begin
                                out_port_next = {out_port_reg[11:0],
                                                 hex_in[4] ? 4'h0 : hex_in[3:0]};
                                if (hex_in[4])
                                    err_next = sfp_pkg::note_error(err_next,
                                                                   sfp_pkg::ST_OUTPORT);
                            end
                            PW'(10):
                            begin
                                if (data_byte != sfp_pkg::CH_STX)
                                    err_next = sfp_pkg::note_error(err_next, sfp_pkg::ST_HEADER);
                            end
                            [PW'(11):PW'(14)]:
                            begin
                                len_next = {len_reg[11:0], hex_in[4] ? 4'h0 : hex_in[3:0]};
                                if (hex_in[4])
                                    err_next = sfp_pkg::note_error(err_next,
                                                                   sfp_pkg::ST_LEN_HEX);
                            end
                            default:
                            begin
                                proto_next = proto_reg;
                            end
                        endcase

                        // fold the byte leaving the delay line; payload once past the header
                        if (pos_reg >= PW'(4))
                            crc_next = sfp_pkg::crc_step(crc_reg, tail_reg[0]);
                        if (pos_reg >= PW'(19))
                        begin
                            count_next = count_reg + PW'(1);
                            if (err_next != sfp_pkg::ST_HEADER)
                            begin
                                res_valid        = 1'b1;
                                res.item_kind    = sfp_pkg::KIND_PAYLOAD;
                                res.payload_char = tail_reg[0];
                            end
                        end

                        tail_next[0] = tail_reg[1];
                        tail_next[1] = tail_reg[2];
                        tail_next[2] = tail_reg[3];
                        tail_next[3] = data_byte;
                        pos_next     = pos_reg + PW'(1);
                    end
                end

                default:
                begin
                    phase_next = sfp_pkg::PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= sfp_pkg::PH_HUNT;
            pos_reg   <= '0;
            count_reg <= '0;
            err_reg   <= sfp_pkg::ST_OK;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            count_reg <= count_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        crc_reg      <= crc_next;
        proto_reg    <= proto_next;
        in_port_reg  <= in_port_next;
        out_port_reg <= out_port_next;
        len_reg      <= len_next;
        for (int k = 0; k < 4; k++)
            tail_reg[k] <= tail_next[k];
    end

    `SFP_ASSERT_IMPL(a_hunt_silent, clk, rst_n,
        advance && phase_reg == sfp_pkg::PH_HUNT, !res_valid,
        "result produced while hunting for SOH")
    `SFP_ASSERT_NEXT(a_status_closes, clk, rst_n,
        advance && res_valid && res.item_kind == sfp_pkg::KIND_STATUS,
        phase_reg == sfp_pkg::PH_HUNT,
        "frame still open after status item")
    `SFP_ASSERT_IMPL(a_payload_pos, clk, rst_n,
        advance && res_valid && res.item_kind == sfp_pkg::KIND_PAYLOAD,
        pos_reg >= PW'(19),
        "payload character emitted inside the header")
    `SFP_ASSERT_IMPL(a_ok_clean, clk, rst_n,
        advance && res_valid && res.item_kind == sfp_pkg::KIND_STATUS
            && res.status == sfp_pkg::ST_OK,
        err_reg == sfp_pkg::ST_OK,
        "ok status despite a recorded header error")
    `SFP_ASSERT_IMPL(a_pos_nonzero, clk, rst_n,
        phase_reg == sfp_pkg::PH_FRAME, pos_reg != '0,
        "frame open with zero byte position")

endmodule

// ===== src/sfp_out_stage.sv =====
module sfp_out_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  sfp_pkg::result_t  res,
    output logic              out_free,
    output logic              m_tvalid,
    input  logic              m_tready,
    output sfp_pkg::result_t  out_item
);

    logic             valid_reg;
    logic             valid_next;
    sfp_pkg::result_t data_reg;

    assign out_free = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (m_tready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= res;
    end

    assign m_tvalid = valid_reg;
    assign out_item = data_reg;

endmodule

// ===== src/soh_stx_etx_frame_parser_crc16.sv =====
// SOH/STX/ETX frame parser with CRC-16/CCITT-FALSE check. Bytes arrive on
// the slave stream one per transfer; the parser drops everything until SOH,
// then walks the frame (protocol byte, two 4-digit hex ports, STX, 4-digit
// hex length, payload text, 4 hex CRC digits, ETX). Payload characters are
// sent out raw on the master stream as they leave a 4-byte delay line, so
// the CRC digits are never sent as payload. At ETX one status transfer goes
// out (m_tuser = 1) carrying the lowest error code found, or on success the
// protocol byte, ports, declared length and received CRC. A frame that
// reaches MAX_FRAME bytes without ETX ends in a too-long status and the
// parser resumes hunting. Rate: one byte per clock cycle, sustained while
// m_tready stays high; the limit is the state update (CRC byte step, hex
// field shifts, position counter) between the input register and the
// output register. A result held by a low m_tready stalls the parser.
// Each accepted byte is held in the input register, and its result in the
// output register. No clearing pass after reset. Configuration
// (APB, registers at 0x0 udp_code, 0x4 tcp_code, 0x8 min_frame_len) should
// only be written while no frame is in progress.

module soh_stx_etx_frame_parser_crc16
(
    input  logic        clk,
    input  logic        rst_n,

    // slave stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte

    // master stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,    // [7:0] payload_char, [11:8] status,
                                    // [19:12] protocol, [35:20] source_port,
                                    // [51:36] dest_port, [67:52] text_length,
                                    // [83:68] frame_check, [87:84] zero
    output logic [0:0]  m_tuser,    // [0] item_kind

    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    sfp_pkg::cfg_t       cfg;
    sfp_pkg::byte_item_t in_item;
    sfp_pkg::result_t    res;
    sfp_pkg::result_t    out_item;
    logic                res_valid;
    logic                out_free;
    logic                advance;

    // process the held byte when the output register can take a result
    assign advance = in_item.valid && out_free;

    sfp_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sfp_in_stage u_in
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .take     (advance),
        .item     (in_item)
    );

    sfp_frame_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .advance   (advance),
        .data_byte (in_item.data),
        .res_valid (res_valid),
        .res       (res)
    );

    sfp_out_stage u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance && res_valid),
        .res      (res),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .out_item (out_item)
    );

    // pack the result, first field in the lowest bits
    assign m_tdata = {4'h0,
                      out_item.frame_check,
                      out_item.text_length,
                      out_item.dest_port,
                      out_item.source_port,
                      out_item.protocol,
                      out_item.status,
                      out_item.payload_char};
    assign m_tuser = out_item.item_kind;

endmodule
